>>> hdl/ptbd_pkg.sv
// ============================================================================
// Point to box distance package
// Shared widths and constants for the point to box distance pipeline.
// ============================================================================
package ptbd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ROOT_GUARD     = 5;
    localparam int DIST_BITS      = 17;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hdl/ptbd_isqrt.sv
// ============================================================================
// Pipelined integer square root
// Restoring square root that settles one root bit per register stage and
// carries a tag word alongside the data.
// ============================================================================
module ptbd_isqrt #(
    parameter int ROOT_BITS = ptbd_pkg::COORD_BITS_DEF + ptbd_pkg::ROOT_GUARD,
    parameter int TAG_BITS  = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     radicand_valid,
    output logic                     radicand_stall,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    input  logic [TAG_BITS-1:0]      tag,
    output logic                     root_valid,
    input  logic                     root_stall,
    output logic [ROOT_BITS-1:0]     root,
    output logic [TAG_BITS-1:0]      root_tag
);

    localparam int RAD_W  = 2 * ROOT_BITS;
    localparam int REM_W  = ROOT_BITS + 1;
    localparam int WIDE_W = ROOT_BITS + 3;

    logic [ROOT_BITS-1:0] valid_reg;
    logic [ROOT_BITS-1:0] adv;
    logic [REM_W-1:0]     rem_reg   [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS];
    logic [RAD_W-1:0]     rad_reg   [ROOT_BITS];
    logic [TAG_BITS-1:0]  tag_reg   [ROOT_BITS];
    logic [REM_W-1:0]     rem_next  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_next [ROOT_BITS];
    logic [RAD_W-1:0]     rad_next  [ROOT_BITS];
    logic [TAG_BITS-1:0]  tag_next  [ROOT_BITS];

    // A stage moves when it is empty or when the stage after it moves.
    always_comb
    begin
        adv[ROOT_BITS-1] = !valid_reg[ROOT_BITS-1] || !root_stall;
        for (int s = ROOT_BITS - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    always_comb
    begin
        logic [REM_W-1:0]     src_rem;
        logic [ROOT_BITS-1:0] src_root;
        logic [RAD_W-1:0]     src_rad;
        logic [WIDE_W-1:0]    rem_wide;
        logic [WIDE_W-1:0]    trial;
        logic [WIDE_W-1:0]    diff;
        for (int s = 0; s < ROOT_BITS; s++)
        begin
            if (s == 0)
            begin
                src_rem     = '0;
                src_root    = '0;
                src_rad     = radicand;
                tag_next[s] = tag;
            end
            else
            begin
                src_rem     = rem_reg[s-1];
                src_root    = root_reg[s-1];
                src_rad     = rad_reg[s-1];
                tag_next[s] = tag_reg[s-1];
            end
            rem_wide = {src_rem, src_rad[RAD_W-1 -: 2]};
            trial    = {1'b0, src_root, 2'b01};
            diff     = rem_wide - trial;
            if (rem_wide >= trial)
            begin
                rem_next[s]  = diff[REM_W-1:0];
                root_next[s] = {src_root[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_wide[REM_W-1:0];
                root_next[s] = {src_root[ROOT_BITS-2:0], 1'b0};
            end
            rad_next[s] = {src_rad[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < ROOT_BITS; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= (s == 0) ? radicand_valid : valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ROOT_BITS; s++)
        begin
            if (adv[s])
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
                tag_reg[s]  <= tag_next[s];
            end
        end
    end

    assign radicand_stall = !adv[0];
    assign root_valid     = valid_reg[ROOT_BITS-1];
    assign root           = root_reg[ROOT_BITS-1];
    assign root_tag       = tag_reg[ROOT_BITS-1];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        radicand_stall |-> valid_reg[0])
        else $error("square root input stalled while its first stage is empty");

    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> root_valid && $stable(root) && $stable(root_tag))
        else $error("stalled square root result changed");

    a_empty_tail_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !root_valid |-> !radicand_stall)
        else $error("square root input stalled while its last stage is empty");
`endif

endmodule

>>> hdl/point_to_box_distance.sv
// ============================================================================
// Point to box distance
// Pipelined Euclidean distance from a point to an axis-aligned box, in
// unsigned fixed point with four fraction bits.
// ============================================================================
// The block takes one query word per cycle while query_stall is low and
// returns one result word per query, in order. Three stages form the axis
// gaps, their squares and the scaled sum; the square root then settles one
// root bit per stage over COORD_BITS + 5 stages, and a final stage saturates
// and registers the result. Each stage holds its word under a stall while
// empty stages upstream of it keep filling.
module point_to_box_distance #(
    parameter int COORD_BITS = ptbd_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              query_valid,
    output logic                              query_stall,
    input  logic [COORD_BITS-1:0]             point_x,
    input  logic [COORD_BITS-1:0]             point_y,
    input  logic [COORD_BITS-1:0]             box_low_x,
    input  logic [COORD_BITS-1:0]             box_low_y,
    input  logic [COORD_BITS-1:0]             box_high_x,
    input  logic [COORD_BITS-1:0]             box_high_y,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              inside_res,
    output logic [ptbd_pkg::DIST_BITS-1:0]    distance_q4
);

    localparam int ROOT_BITS = COORD_BITS + ptbd_pkg::ROOT_GUARD;
    localparam int RAD_W     = 2 * ROOT_BITS;
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int CMP_W     = ptbd_pkg::max_int(ROOT_BITS, ptbd_pkg::DIST_BITS);

    // Stage 1: axis gaps and inside test.
    logic                  v1_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic                  in1_reg, in1_next;
    // Stage 2: squares.
    logic                  v2_reg;
    logic [SQ_W-1:0]       sx_reg, sy_reg;
    logic                  in2_reg;
    // Stage 3: scaled radicand.
    logic                  v3_reg;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic                  in3_reg;
    // Output stage.
    logic                  out_valid_reg;
    logic                  inside_reg;
    logic [ptbd_pkg::DIST_BITS-1:0] dist_reg, dist_next;

    logic                  adv1, adv2, adv3, adv_out;
    logic                  sq_stall;
    logic                  root_valid;
    logic [ROOT_BITS-1:0]  root;
    logic                  root_inside;
    logic [CMP_W-1:0]      root_wide;

    always_comb
    begin
        logic [COORD_BITS-1:0] below_x, above_x, below_y, above_y;
        below_x  = (box_low_x > point_x) ? (box_low_x - point_x) : '0;
        above_x  = (point_x > box_high_x) ? (point_x - box_high_x) : '0;
        below_y  = (box_low_y > point_y) ? (box_low_y - point_y) : '0;
        above_y  = (point_y > box_high_y) ? (point_y - box_high_y) : '0;
        dx_next  = (below_x > above_x) ? below_x : above_x;
        dy_next  = (below_y > above_y) ? below_y : above_y;
        in1_next = (box_low_x < point_x) && (point_x < box_high_x) &&
                   (box_low_y < point_y) && (point_y < box_high_y);
    end

    always_comb
    begin
        logic [SQ_W:0] sum;
        sum      = {1'b0, sx_reg} + {1'b0, sy_reg};
        rad_next = in2_reg ? '0 : {{(RAD_W-SQ_W-9){1'b0}}, sum, 8'd0};
    end

    assign root_wide = CMP_W'(root);

    always_comb
    begin
        if (root_wide > CMP_W'(ptbd_pkg::DIST_MAX))
        begin
            dist_next = ptbd_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = root_wide[ptbd_pkg::DIST_BITS-1:0];
        end
    end

    assign adv_out = !out_valid_reg || !result_stall;
    assign adv3    = !v3_reg || !sq_stall;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= query_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= root_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            in1_reg <= in1_next;
        end
        if (adv2)
        begin
            sx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            sy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            in2_reg <= in1_reg;
        end
        if (adv3)
        begin
            rad_reg <= rad_next;
            in3_reg <= in2_reg;
        end
        if (adv_out)
        begin
            inside_reg <= root_inside;
            dist_reg   <= dist_next;
        end
    end

    ptbd_isqrt #(
        .ROOT_BITS (ROOT_BITS),
        .TAG_BITS  (1)
    ) u_isqrt (
        .clk            (clk),
        .rst_n          (rst_n),
        .radicand_valid (v3_reg),
        .radicand_stall (sq_stall),
        .radicand       (rad_reg),
        .tag            (in3_reg),
        .root_valid     (root_valid),
        .root_stall     (!adv_out),
        .root           (root),
        .root_tag       (root_inside)
    );

    assign query_stall  = !adv1;
    assign result_valid = out_valid_reg;
    assign inside_res   = inside_reg;
    assign distance_q4  = dist_reg;

`ifndef SYNTHESIS
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && inside_res |-> distance_q4 == '0)
        else $error("inside result carries a nonzero distance");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> v1_reg && v2_reg && v3_reg)
        else $error("query stalled while the front stages have room");

    a_radicand_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && sq_stall |=> v3_reg && $stable(rad_reg) && $stable(in3_reg))
        else $error("stalled radicand changed");
`endif

endmodule
